@@ src/cassm_pkg.sv @@
// Shared types, constants and day/time match functions for the alarm matcher.
package cassm_pkg;

    localparam int REG_CHANNELS = 2;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 30;
    localparam int DM_W         = 30;
    localparam int TM_W         = 23;
    localparam int STAMP_W      = 32;
    localparam int QUEUE_DEPTH  = 4;

    localparam logic [STAMP_W-1:0] STAMP_NONE = '1;

    // low bit of the register index selects the register within a channel
    localparam logic CFG_DATE_MODE = 1'b0;
    localparam logic CFG_TIMES     = 1'b1;

    typedef struct packed {
        logic [11:0]        cal_year;
        logic [3:0]         cal_month;
        logic [4:0]         cal_day;
        logic [2:0]         week_day;
        logic [4:0]         clock_hour;
        logic [5:0]         clock_minute;
        logic [STAMP_W-1:0] minute_stamp;
    } t_tick;

    typedef struct packed {
        logic [TM_W-1:0] times;
        logic [DM_W-1:0] date_mode;
    } t_chan_cfg;

    // Monday-first mask bit for a Sunday-based weekday; weekday seven hits nothing
    function automatic logic [6:0] weekday_bit(input logic [2:0] wd);
        logic [6:0] r;
        unique case (wd)
            3'd0:    r = 7'b1000000;
            3'd1:    r = 7'b0000001;
            3'd2:    r = 7'b0000010;
            3'd3:    r = 7'b0000100;
            3'd4:    r = 7'b0001000;
            3'd5:    r = 7'b0010000;
            3'd6:    r = 7'b0100000;
            default: r = 7'b0000000;
        endcase
        return r;
    endfunction

    function automatic logic due(input logic [DM_W-1:0] dm, input logic [4:0] hr,
                                 input logic [5:0] mn, input t_tick t);
        logic day_ok;
        if (dm[1]) begin
            day_ok = |(dm[8:2] & weekday_bit(t.week_day));
        end else begin
            day_ok = (t.cal_year == dm[29:18]) && (t.cal_month == dm[17:14]) &&
                     (t.cal_day == dm[13:9]);
        end
        return (t.clock_hour == hr) && (t.clock_minute == mn) && day_ok;
    endfunction

endpackage

@@ src/calendar_alarm_start_stop_matcher.sv @@
// Top level: calendar alarm matcher with start and stop actions per channel.
//
// Ticks enter through a queue-style port: a tick is taken when i_push is high
// and o_full is low. Actions leave the same way: the oldest action is shown
// while o_empty is low and is taken when i_pop is high. Registers are written
// through i_cfg_valid / o_cfg_ready (always ready), index and data; write only
// while no actions are pending.
// A tick is matched against every channel in the cycle it is taken, and its
// hit word, if any bit is set, goes into a four-entry queue. The back end loads
// the oldest word from the queue into its pending register and then shows one
// action per cycle while i_pop is high, up to two per channel. Ticks are taken
// one per cycle while the queue has room; a stalled receiver fills the queue
// and raises o_full.
// Reset clears all registers and armed bits, sets the minute stamps to all
// ones and empties the queue.
module calendar_alarm_start_stop_matcher #(
    parameter int NUM_CHANNELS = 2
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_push,
    output logic                              o_full,
    input  logic [11:0]                       i_cal_year,
    input  logic [3:0]                        i_cal_month,
    input  logic [4:0]                        i_cal_day,
    input  logic [2:0]                        i_week_day,
    input  logic [4:0]                        i_clock_hour,
    input  logic [5:0]                        i_clock_minute,
    input  logic [31:0]                       i_minute_stamp,
    output logic                              o_empty,
    input  logic                              i_pop,
    output logic                              o_channel,
    output logic                              o_is_start,
    output logic                              o_last_action,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [cassm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [cassm_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import cassm_pkg::*;

    localparam int HW = 2 * NUM_CHANNELS;

    t_tick         tick;
    logic [HW-1:0] hits;
    logic          hit_push;
    logic          q_full;
    logic          q_pop;
    logic          q_empty;
    logic [HW-1:0] q_data;

    assign tick.cal_year     = i_cal_year;
    assign tick.cal_month    = i_cal_month;
    assign tick.cal_day      = i_cal_day;
    assign tick.week_day     = i_week_day;
    assign tick.clock_hour   = i_clock_hour;
    assign tick.clock_minute = i_clock_minute;
    assign tick.minute_stamp = i_minute_stamp;

    assign o_full      = q_full;
    assign o_cfg_ready = 1'b1;

    cassm_front #(.NUM_CHANNELS(NUM_CHANNELS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .i_q_full    (q_full),
        .i_tick      (tick),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_hits      (hits),
        .o_hit_push  (hit_push)
    );

    cassm_queue #(.WIDTH(HW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (hit_push),
        .i_data  (hits),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_data),
        .o_empty (q_empty)
    );

    cassm_back #(.NUM_CHANNELS(NUM_CHANNELS)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_data      (q_data),
        .i_q_empty     (q_empty),
        .o_q_pop       (q_pop),
        .i_pop         (i_pop),
        .o_empty       (o_empty),
        .o_channel     (o_channel),
        .o_is_start    (o_is_start),
        .o_last_action (o_last_action)
    );

endmodule

@@ src/cassm_front.sv @@
// Front end: register file, per-channel match and once-per-minute state.
module cassm_front #(
    parameter int NUM_CHANNELS = 2
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_push,
    input  logic                              i_q_full,
    input  cassm_pkg::t_tick                  i_tick,
    input  logic                              i_cfg_valid,
    input  logic [cassm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [cassm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic [2*NUM_CHANNELS-1:0]         o_hits,
    output logic                              o_hit_push
);
    import cassm_pkg::*;

    t_chan_cfg          r_cfg        [NUM_CHANNELS];
    logic               r_armed      [NUM_CHANNELS];
    logic [STAMP_W-1:0] r_last_start [NUM_CHANNELS];
    logic [STAMP_W-1:0] r_last_stop  [NUM_CHANNELS];

    logic [NUM_CHANNELS-1:0] start_hit;
    logic [NUM_CHANNELS-1:0] stop_hit;
    logic                    accept;

    assign accept = i_push && !i_q_full;

    always_comb begin
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            start_hit[c] = r_armed[c] && (r_last_start[c] != i_tick.minute_stamp) &&
                           due(r_cfg[c].date_mode, r_cfg[c].times[4:0],
                               r_cfg[c].times[10:5], i_tick);
            stop_hit[c]  = r_armed[c] && r_cfg[c].times[11] &&
                           (r_last_stop[c] != i_tick.minute_stamp) &&
                           due(r_cfg[c].date_mode, r_cfg[c].times[16:12],
                               r_cfg[c].times[22:17], i_tick);
            o_hits[2*c]   = start_hit[c];
            o_hits[2*c+1] = stop_hit[c];
        end
    end

    assign o_hit_push = accept && (|o_hits);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                r_cfg[c]        <= '0;
                r_armed[c]      <= 1'b0;
                r_last_start[c] <= STAMP_NONE;
                r_last_stop[c]  <= STAMP_NONE;
            end
        end else begin
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                if (accept) begin
                    if (start_hit[c]) begin
                        r_last_start[c] <= i_tick.minute_stamp;
                        if (!r_cfg[c].date_mode[1]) begin
                            r_armed[c] <= 1'b0;
                        end
                    end
                    if (stop_hit[c]) begin
                        r_last_stop[c] <= i_tick.minute_stamp;
                    end
                end
                if (i_cfg_valid && (int'(i_cfg_index[1]) == c) && (c < REG_CHANNELS)) begin
                    if (i_cfg_index[0] == CFG_DATE_MODE) begin
                        r_cfg[c].date_mode <= i_cfg_data[DM_W-1:0];
                        r_armed[c]         <= i_cfg_data[0];
                    end else begin
                        r_cfg[c].times <= i_cfg_data[TM_W-1:0];
                    end
                end
            end
        end
    end

endmodule

@@ src/cassm_queue.sv @@
// Small first-word-fall-through queue of hit words between front and back.
module cassm_queue #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [CW-1:0]    r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= bump(r_wr);
            end
            if (do_pop) begin
                r_rd <= bump(r_rd);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ src/cassm_back.sv @@
// Back end: drain one hit word, one action per pop, lowest channel first.
module cassm_back #(
    parameter int NUM_CHANNELS = 2
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [2*NUM_CHANNELS-1:0] i_q_data,
    input  logic                      i_q_empty,
    output logic                      o_q_pop,
    input  logic                      i_pop,
    output logic                      o_empty,
    output logic                      o_channel,
    output logic                      o_is_start,
    output logic                      o_last_action
);
    localparam int HW = 2 * NUM_CHANNELS;

    logic [HW-1:0] r_pend;
    logic [HW-1:0] n_pend;
    logic          r_valid;
    logic          n_valid;
    logic [HW-1:0] low;
    logic [HW-1:0] rest;
    logic [HW-1:0] start_mask;
    logic [HW-1:0] ch1_mask;
    logic          take;

    always_comb begin
        for (int i = 0; i < HW; i++) begin
            start_mask[i] = ((i % 2) == 0);
            ch1_mask[i]   = (((i / 2) % 2) == 1);
        end
    end

    assign low           = r_pend & (~r_pend + 1'b1);
    assign rest          = r_pend & ~low;
    assign o_empty       = !r_valid;
    assign o_channel     = |(low & ch1_mask);
    assign o_is_start    = |(low & start_mask);
    assign o_last_action = (rest == '0);
    assign take          = r_valid && i_pop;
    assign o_q_pop       = !i_q_empty && (!r_valid || (take && o_last_action));

    always_comb begin
        n_pend  = r_pend;
        n_valid = r_valid;
        if (o_q_pop) begin
            n_pend  = i_q_data;
            n_valid = 1'b1;
        end else if (take) begin
            n_pend  = rest;
            n_valid = !o_last_action;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
    end

endmodule

@@ tb/calendar_alarm_start_stop_matcher_chk.sv @@
// Checker for the alarm matcher: shadows the registers, predicts action words and compares.
module calendar_alarm_start_stop_matcher_chk (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_push,
    input  logic                              o_full,
    input  logic [11:0]                       i_cal_year,
    input  logic [3:0]                        i_cal_month,
    input  logic [4:0]                        i_cal_day,
    input  logic [2:0]                        i_week_day,
    input  logic [4:0]                        i_clock_hour,
    input  logic [5:0]                        i_clock_minute,
    input  logic [31:0]                       i_minute_stamp,
    input  logic                              o_empty,
    input  logic                              i_pop,
    input  logic                              o_channel,
    input  logic                              o_is_start,
    input  logic                              o_last_action,
    input  logic                              i_cfg_valid,
    input  logic                              o_cfg_ready,
    input  logic [cassm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [cassm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output int                                o_fail_count,
    output int                                o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import cassm_pkg::*;

    typedef struct packed {
        logic channel;
        logic is_start;
        logic last_action;
    } t_action;

    t_action             action_q[$];
    logic [DM_W-1:0]     date_mode_r   [REG_CHANNELS];
    logic [TM_W-1:0]     times_r       [REG_CHANNELS];
    logic                armed_r       [REG_CHANNELS];
    logic [STAMP_W-1:0]  start_stamp_r [REG_CHANNELS];
    logic [STAMP_W-1:0]  stop_stamp_r  [REG_CHANNELS];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        o_fail_count++;
    endtask

    function automatic logic day_matches(input logic [DM_W-1:0] dm, input t_tick t);
        int bit_idx;
        if (dm[1]) begin
            if (t.week_day > 3'd6) return 1'b0;
            bit_idx = 2 + (int'(t.week_day) + 6) % 7;
            return dm[bit_idx];
        end
        return (t.cal_year == dm[29:18]) && (t.cal_month == dm[17:14]) &&
               (t.cal_day == dm[13:9]);
    endfunction

    function automatic logic slot_due(input logic [DM_W-1:0] dm, input logic [4:0] hr,
                                      input logic [5:0] mn, input t_tick t);
        return (t.clock_hour == hr) && (t.clock_minute == mn) && day_matches(dm, t);
    endfunction

    task automatic add_action(input int c, input logic start);
        t_action a;
        a.channel     = c[0];
        a.is_start    = start;
        a.last_action = 1'b0;
        action_q.insert(action_q.size(), a);
    endtask

    task automatic predict_actions(input t_tick t);
        int base;
        base = action_q.size();
        for (int c = 0; c < REG_CHANNELS; c++) begin
            if (armed_r[c]) begin
                if (start_stamp_r[c] != t.minute_stamp &&
                    slot_due(date_mode_r[c], times_r[c][4:0], times_r[c][10:5], t)) begin
                    start_stamp_r[c] = t.minute_stamp;
                    add_action(c, 1'b1);
                    if (!date_mode_r[c][1]) armed_r[c] = 1'b0;
                end
                if (times_r[c][11] && stop_stamp_r[c] != t.minute_stamp &&
                    slot_due(date_mode_r[c], times_r[c][16:12], times_r[c][22:17], t)) begin
                    stop_stamp_r[c] = t.minute_stamp;
                    add_action(c, 1'b0);
                end
            end
        end
        if (action_q.size() > base) action_q[action_q.size() - 1].last_action = 1'b1;
    endtask

    task automatic check_word();
        t_action want;
        if (action_q.size() == 0) begin
            report_mismatch($sformatf("unexpected word channel=%0b is_start=%0b last=%0b",
                                      o_channel, o_is_start, o_last_action));
        end else begin
            want = action_q.pop_front();
            if (o_channel !== want.channel)
                report_mismatch($sformatf("channel got %0b want %0b",
                                          o_channel, want.channel));
            if (o_is_start !== want.is_start)
                report_mismatch($sformatf("is_start got %0b want %0b",
                                          o_is_start, want.is_start));
            if (o_last_action !== want.last_action)
                report_mismatch($sformatf("last_action got %0b want %0b",
                                          o_last_action, want.last_action));
        end
    endtask

    always @(posedge i_clk) begin
        t_tick t;
        if (!i_rst_n) begin
            for (int c = 0; c < REG_CHANNELS; c++) begin
                date_mode_r[c]   = '0;
                times_r[c]       = '0;
                armed_r[c]       = 1'b0;
                start_stamp_r[c] = STAMP_NONE;
                stop_stamp_r[c]  = STAMP_NONE;
            end
            action_q.delete();
        end else begin
            if (i_pop && !o_empty) check_word();
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index[0] == CFG_DATE_MODE) begin
                    date_mode_r[i_cfg_index[1]] = i_cfg_data[DM_W-1:0];
                    armed_r[i_cfg_index[1]]     = i_cfg_data[0];
                end else begin
                    times_r[i_cfg_index[1]] = i_cfg_data[TM_W-1:0];
                end
            end
            if (i_push && !o_full) begin
                t.cal_year     = i_cal_year;
                t.cal_month    = i_cal_month;
                t.cal_day      = i_cal_day;
                t.week_day     = i_week_day;
                t.clock_hour   = i_clock_hour;
                t.clock_minute = i_clock_minute;
                t.minute_stamp = i_minute_stamp;
                predict_actions(t);
            end
        end
        o_pending <= action_q.size();
    end

endmodule

@@ tb/calendar_alarm_start_stop_matcher_tb.sv @@
// Testbench top for the alarm matcher: clock, reset, tick and register stimulus, verdict.
module calendar_alarm_start_stop_matcher_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cassm_pkg::*;

    localparam int RESET_CYCLES    = 9;
    localparam int HOLD_CYCLES     = 80;
    localparam int SETTLE_CYCLES   = 12;
    localparam int IDLE_LIMIT      = 3000;
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 29;
    localparam int HOLD_PHASE      = 2;

    logic                   i_clk          = 1'b0;
    logic                   i_rst_n        = 1'b0;
    logic                   i_push         = 1'b0;
    logic                   o_full;
    logic [11:0]            i_cal_year     = '0;
    logic [3:0]             i_cal_month    = '0;
    logic [4:0]             i_cal_day      = '0;
    logic [2:0]             i_week_day     = '0;
    logic [4:0]             i_clock_hour   = '0;
    logic [5:0]             i_clock_minute = '0;
    logic [31:0]            i_minute_stamp = '0;
    logic                   o_empty;
    logic                   i_pop          = 1'b0;
    logic                   o_channel;
    logic                   o_is_start;
    logic                   o_last_action;
    logic                   i_cfg_valid    = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index    = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data     = '0;

    int                     fail_count;
    int                     pending;
    int                     idle_odds  = 0;
    logic                   hold_req   = 1'b0;
    logic [CFG_DATA_W-1:0]  cfg_dm [REG_CHANNELS];
    logic [CFG_DATA_W-1:0]  cfg_tm [REG_CHANNELS];
    logic [STAMP_W-1:0]     last_stamp = '0;

    calendar_alarm_start_stop_matcher dut (.*);

    calendar_alarm_start_stop_matcher_chk action_chk (
        .*,
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_tick mk_tick(input int year, input int month, input int day,
                                      input int wd, input int hr, input int mn,
                                      input logic [31:0] stamp);
        t_tick t;
        t.cal_year     = 12'(year);
        t.cal_month    = 4'(month);
        t.cal_day      = 5'(day);
        t.week_day     = 3'(wd);
        t.clock_hour   = 5'(hr);
        t.clock_minute = 6'(mn);
        t.minute_stamp = stamp;
        return t;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx[0] == CFG_DATE_MODE) cfg_dm[idx[1]] = data;
        else cfg_tm[idx[1]] = data;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic write_channel(input int c, input logic [CFG_DATA_W-1:0] dm,
                                 input logic [CFG_DATA_W-1:0] tm);
        write_reg({c[0], CFG_DATE_MODE}, dm);
        write_reg({c[0], CFG_TIMES}, tm);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_push <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic send_tick(input t_tick t, input int gap);
        if (gap > 0) begin
            @(negedge i_clk);
            i_push <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_push         <= 1'b1;
        i_cal_year     <= t.cal_year;
        i_cal_month    <= t.cal_month;
        i_cal_day      <= t.cal_day;
        i_week_day     <= t.week_day;
        i_clock_hour   <= t.clock_hour;
        i_clock_minute <= t.clock_minute;
        i_minute_stamp <= t.minute_stamp;
        do @(posedge i_clk); while (o_full);
    endtask

    function automatic logic [CFG_DATA_W-1:0] rand_date_mode();
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [6:0]  mask;
        logic        daily;
        logic        en;
        year  = 12'($urandom);
        month = 4'($urandom);
        day   = 5'($urandom);
        mask  = 7'($urandom);
        daily = 1'($urandom_range(0, 1));
        en    = ($urandom_range(0, 9) != 0);
        return {year, month, day, mask, daily, en};
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_times();
        logic [4:0] start_hr;
        logic [5:0] start_mn;
        logic [4:0] stop_hr;
        logic [5:0] stop_mn;
        logic       stop_en;
        logic [6:0] junk;
        start_hr = 5'($urandom);
        start_mn = 6'($urandom);
        stop_en  = ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 2) == 0) begin
            stop_hr = start_hr;
            stop_mn = start_mn;
        end else begin
            stop_hr = 5'($urandom);
            stop_mn = 6'($urandom);
        end
        junk = 7'($urandom);
        return {junk, stop_mn, stop_hr, stop_en, start_mn, start_hr};
    endfunction

    task automatic make_tick(output t_tick t);
        int                    c;
        int                    r;
        logic [CFG_DATA_W-1:0] dm;
        logic [CFG_DATA_W-1:0] tm;
        c  = $urandom_range(0, REG_CHANNELS - 1);
        dm = cfg_dm[c];
        tm = cfg_tm[c];
        r  = $urandom_range(0, 19);
        if (r == 0) last_stamp = STAMP_NONE;
        else if (r == 1) last_stamp = $urandom;
        else if (r >= 6) last_stamp = last_stamp + $urandom_range(1, 3);
        t.minute_stamp = last_stamp;
        t.week_day     = 3'($urandom_range(0, 7));
        if ($urandom_range(0, 4) == 0) begin
            t.cal_year     = 12'($urandom);
            t.cal_month    = 4'($urandom);
            t.cal_day      = 5'($urandom);
            t.clock_hour   = 5'($urandom);
            t.clock_minute = 6'($urandom);
        end else begin
            if ($urandom_range(0, 1) == 1) begin
                t.clock_hour   = tm[16:12];
                t.clock_minute = tm[22:17];
            end else begin
                t.clock_hour   = tm[4:0];
                t.clock_minute = tm[10:5];
            end
            if ($urandom_range(0, 9) == 0) t.clock_minute = 6'($urandom);
            if ($urandom_range(0, 5) != 0) begin
                t.cal_year  = dm[29:18];
                t.cal_month = dm[17:14];
                t.cal_day   = dm[13:9];
            end else begin
                t.cal_year  = 12'($urandom);
                t.cal_month = 4'($urandom);
                t.cal_day   = 5'($urandom);
            end
        end
    endtask

    // receiver: random stalls, one long hold-off on request
    initial begin : pop_driver
        int n;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_pop <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
                n = $urandom_range(1, 15);
                i_pop <= 1'b0;
                repeat (n - 1) @(negedge i_clk);
            end else begin
                i_pop <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_push && !o_full) || (i_pop && !o_empty) ||
                (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin : stimulus
        t_tick                 t;
        int                    gap;
        logic [CFG_DATA_W-1:0] dm;
        logic [CFG_DATA_W-1:0] tm;
        for (int c = 0; c < REG_CHANNELS; c++) begin
            cfg_dm[c] = '0;
            cfg_tm[c] = '0;
        end
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // registers at reset: nothing armed
        send_tick(mk_tick(0, 0, 0, 0, 0, 0, 0), 0);
        wait_idle();

        // daily every weekday at midnight with stop; one-shot at the top of every field
        write_channel(0, 30'h0000_01FF, 30'h0000_0800);
        write_channel(1, 30'h3FFF_FE01, 30'h007F_FFFF);
        send_tick(mk_tick(0, 1, 1, 1, 0, 0, STAMP_NONE), 0);
        send_tick(mk_tick(0, 1, 1, 1, 0, 0, 0), 0);
        send_tick(mk_tick(0, 1, 1, 1, 0, 0, 0), 0);
        for (int wd = 0; wd < 8; wd++) send_tick(mk_tick(0, 1, 1, wd, 0, 0, wd + 1), 0);
        send_tick(mk_tick(4095, 15, 31, 7, 31, 63, 9), 0);
        send_tick(mk_tick(4095, 15, 31, 7, 31, 63, 10), 0);
        wait_idle();

        // one-shot on the all-zero date; daily with every bit set and junk above the times
        write_channel(0, 30'h0000_0001, 30'h0000_0000);
        write_channel(1, 30'h3FFF_FFFF, 30'h3FFF_FFFF);
        send_tick(mk_tick(0, 0, 0, 0, 0, 0, 11), 0);
        send_tick(mk_tick(0, 0, 0, 0, 31, 63, 12), 0);
        send_tick(mk_tick(0, 0, 0, 7, 31, 63, 13), 0);
        send_tick(mk_tick(0, 0, 0, 6, 31, 63, 12), 0);
        wait_idle();

        // both channels start and stop on the same tick
        write_channel(0, 30'h0000_01FF, 30'h0000_0800);
        write_channel(1, 30'h0000_01FF, 30'h0000_0800);
        send_tick(mk_tick(0, 1, 1, 1, 0, 0, 20), 0);
        wait_idle();
        last_stamp = 100;

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            for (int c = 0; c < REG_CHANNELS; c++) begin
                dm = rand_date_mode();
                tm = rand_times();
                if (c == 1 && $urandom_range(0, 2) == 0) begin
                    dm = cfg_dm[0];
                    tm = cfg_tm[0];
                end
                write_channel(c, dm, tm);
            end
            unique case (phase % 3)
                0:       idle_odds = 0;
                1:       idle_odds = 4;
                default: idle_odds = 12;
            endcase
            if (phase == NUM_PHASES - 1) idle_odds = 0;
            if (phase == HOLD_PHASE) hold_req = 1'b1;
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (k == ITEMS_PER_PHASE / 2) begin
                    // drain, then rewrite both date-mode registers to rearm the enabled channels
                    wait_idle();
                    write_reg({1'b0, CFG_DATE_MODE}, cfg_dm[0]);
                    write_reg({1'b1, CFG_DATE_MODE}, cfg_dm[1]);
                end
                gap = 0;
                if (!(phase == HOLD_PHASE && k < 12) && idle_odds != 0 &&
                    $urandom_range(1, idle_odds) == 1)
                    gap = $urandom_range(1, 15);
                make_tick(t);
                send_tick(t, gap);
            end
            wait_idle();
        end

        if (fail_count == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
